>>> hdl/lpr_pkg.sv
// shared types, codes and helpers for the longest-prefix routing block
package lpr_pkg;

	localparam int ADDR_W = 32;
	localparam int LEN_W  = 6;
	localparam int PORT_W = 4;
	localparam int TTL_W  = 8;
	// wide enough for a route count up to the largest supported table
	localparam int CNT_W  = 11;

	typedef enum logic [0:0] {
		REQ_ADD    = 1'b0,
		REQ_LOOKUP = 1'b1
	} lpr_req_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_FULL     = 3'd1,
		ST_FORWARD  = 3'd2,
		ST_NO_ROUTE = 3'd3,
		ST_TTL_DROP = 3'd4
	} lpr_status_t;

	// one request as it walks down the row of cells
	typedef struct packed {
		logic                valid;
		lpr_req_t            req_type;
		logic                full;
		logic [CNT_W-1:0]    cnt;
		logic [ADDR_W-1:0]   prefix;
		logic [LEN_W-1:0]    len;
		logic                hop_present;
		logic [ADDR_W-1:0]   hop_addr;
		logic [PORT_W-1:0]   port;
		logic [ADDR_W-1:0]   dest;
		logic [TTL_W-1:0]    ttl;
		logic                found;
		logic [LEN_W-1:0]    best_len;
		logic [PORT_W-1:0]   best_port;
		logic [ADDR_W-1:0]   best_send;
	} lpr_item_t;

	// top len bits set, len already limited to 0..32
	function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] ones;
		ones = '1;
		return ~(ones >> len);
	endfunction

endpackage

>>> hdl/lpr_ifs.sv
// request and result channels of the routing block
interface lpr_req_if;
	logic        valid;
	logic        ready;
	logic [0:0]  req_type;
	logic [31:0] net_prefix;
	logic [5:0]  prefix_len;
	logic        hop_present;
	logic [31:0] hop_addr;
	logic [3:0]  port_index;
	logic [31:0] dest_addr;
	logic [7:0]  ttl_in;

	modport source (
		output valid, req_type, net_prefix, prefix_len, hop_present, hop_addr,
		       port_index, dest_addr, ttl_in,
		input  ready
	);
	modport sink (
		input  valid, req_type, net_prefix, prefix_len, hop_present, hop_addr,
		       port_index, dest_addr, ttl_in,
		output ready
	);
endinterface

interface lpr_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  out_port;
	logic [31:0] send_addr;
	logic [7:0]  ttl_out;

	modport source (
		output valid, status, out_port, send_addr, ttl_out,
		input  ready
	);
	modport sink (
		input  valid, status, out_port, send_addr, ttl_out,
		output ready
	);
endinterface

>>> hdl/ipv4_longest_prefix_router.sv
// ipv4 longest-prefix routing table built as a row of entry cells
//
// req channel carries add and lookup requests; rsp channel returns one result per
// request, in request order. Each route lives in its own cell. A request walks the
// row one cell per cycle: an add is captured by the cell whose number equals the
// route count at entry, a lookup compares against every filled cell on its way and
// keeps the longest match seen so far. Adds and lookups therefore see the table
// exactly as it was when they entered.
// A result passes through the stage register of every cell in the row and then the
// result register. A new request is taken every cycle while the receiver does not
// stall, so throughput is then one request per cycle.
// Reset clears the route count and all stage valid flags; the table needs no
// clearing pass since only counted routes are ever compared.
// When the receiver stalls with a result waiting, the whole row holds and req.ready
// drops until the result is taken.
module ipv4_longest_prefix_router #(
	parameter int TABLE_DEPTH = 64,
	parameter int NUM_PORTS   = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	lpr_req_if.sink   req,
	lpr_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int PORTS = 1 << lpr_pkg::PORT_W;

	typedef logic [PORTS-1:0][lpr_pkg::PORT_W-1:0] port_tab_t;

	function automatic port_tab_t make_port_tab();
		port_tab_t tab;
		for (int i = 0; i < PORTS; i++) begin
			tab[i] = lpr_pkg::PORT_W'(i % NUM_PORTS);
		end
		return tab;
	endfunction

	localparam port_tab_t PORT_MOD = make_port_tab();

	logic [CNT_W-1:0]    count_q;
	logic                advance;
	logic                full;
	logic                req_xfer;
	lpr_pkg::lpr_item_t  link [TABLE_DEPTH+1];
	lpr_pkg::lpr_item_t  tail;

	logic                        rsp_valid_q;
	lpr_pkg::lpr_status_t        status_q;
	logic [lpr_pkg::PORT_W-1:0]  out_port_q;
	logic [lpr_pkg::ADDR_W-1:0]  send_addr_q;
	logic [lpr_pkg::TTL_W-1:0]   ttl_out_q;

	lpr_pkg::lpr_status_t        status_nxt;
	logic [lpr_pkg::PORT_W-1:0]  out_port_nxt;
	logic [lpr_pkg::ADDR_W-1:0]  send_addr_nxt;
	logic [lpr_pkg::TTL_W-1:0]   ttl_out_nxt;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = advance;
	assign req_xfer  = req.valid && advance;
	assign full      = count_q == CNT_W'(TABLE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (req_xfer && req.req_type == lpr_pkg::REQ_ADD && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// entry of the row
	always_comb begin
		link[0]             = '0;
		link[0].valid       = req.valid;
		link[0].req_type    = lpr_pkg::lpr_req_t'(req.req_type);
		link[0].full        = full;
		link[0].cnt         = lpr_pkg::CNT_W'(count_q);
		link[0].prefix      = req.net_prefix;
		// lengths above 32 match and rank as 32
		link[0].len         = (req.prefix_len > lpr_pkg::LEN_W'(lpr_pkg::ADDR_W)) ?
		                      lpr_pkg::LEN_W'(lpr_pkg::ADDR_W) : req.prefix_len;
		link[0].hop_present = req.hop_present;
		link[0].hop_addr    = req.hop_addr;
		link[0].port        = PORT_MOD[req.port_index];
		link[0].dest        = req.dest_addr;
		link[0].ttl         = req.ttl_in;
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		lpr_cell #(
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.item_in  (link[i]),
			.item_out (link[i+1])
		);
	end

	assign tail = link[TABLE_DEPTH];

	always_comb begin
		status_nxt    = lpr_pkg::ST_ADDED;
		out_port_nxt  = '0;
		send_addr_nxt = '0;
		ttl_out_nxt   = '0;
		if (tail.req_type == lpr_pkg::REQ_ADD) begin
			status_nxt = tail.full ? lpr_pkg::ST_FULL : lpr_pkg::ST_ADDED;
		end else if (!tail.found) begin
			status_nxt = lpr_pkg::ST_NO_ROUTE;
		end else if (tail.ttl <= lpr_pkg::TTL_W'(1)) begin
			status_nxt = lpr_pkg::ST_TTL_DROP;
		end else begin
			status_nxt    = lpr_pkg::ST_FORWARD;
			out_port_nxt  = tail.best_port;
			send_addr_nxt = tail.best_send;
			ttl_out_nxt   = tail.ttl - lpr_pkg::TTL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q    <= status_nxt;
			out_port_q  <= out_port_nxt;
			send_addr_q <= send_addr_nxt;
			ttl_out_q   <= ttl_out_nxt;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.out_port  = out_port_q;
	assign rsp.send_addr = send_addr_q;
	assign rsp.ttl_out   = ttl_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("route count beyond table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && req.req_type == lpr_pkg::REQ_ADD && !full) |=>
		count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted add did not advance route count");

	a_stall_holds_row: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("request taken while result stalled");

	a_forward_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == lpr_pkg::ST_FORWARD) |-> rsp.ttl_out != '0)
		else $error("forwarded datagram with zero ttl");

endmodule

>>> hdl/lpr_cell.sv
// one routing table entry with its compare logic and its stage register
module lpr_cell #(
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  lpr_pkg::lpr_item_t item_in,
	output lpr_pkg::lpr_item_t item_out
);

	logic [lpr_pkg::ADDR_W-1:0] prefix_q;
	logic [lpr_pkg::LEN_W-1:0]  len_q;
	logic                       hop_present_q;
	logic [lpr_pkg::ADDR_W-1:0] hop_addr_q;
	logic [lpr_pkg::PORT_W-1:0] port_q;

	lpr_pkg::lpr_item_t item_nxt;
	lpr_pkg::lpr_item_t item_q;
	logic               mine;
	logic               occupied;
	logic               hit;

	// this cell holds route number INDEX
	assign mine     = item_in.cnt == lpr_pkg::CNT_W'(INDEX);
	assign occupied = lpr_pkg::CNT_W'(INDEX) < item_in.cnt;
	assign hit      = ((prefix_q ^ item_in.dest) & lpr_pkg::len_mask(len_q)) == '0;

	always_comb begin
		item_nxt = item_in;
		// strictly longer wins, so the earlier route keeps a tie
		if (item_in.req_type == lpr_pkg::REQ_LOOKUP && occupied && hit &&
		    (!item_in.found || len_q > item_in.best_len)) begin
			item_nxt.found     = 1'b1;
			item_nxt.best_len  = len_q;
			item_nxt.best_port = port_q;
			item_nxt.best_send = hop_present_q ? hop_addr_q : item_in.dest;
		end
	end

	always_ff @(posedge clk) begin
		if (en && item_in.valid && item_in.req_type == lpr_pkg::REQ_ADD &&
		    !item_in.full && mine) begin
			prefix_q      <= item_in.prefix;
			len_q         <= item_in.len;
			hop_present_q <= item_in.hop_present;
			hop_addr_q    <= item_in.hop_addr;
			port_q        <= item_in.port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else if (en) begin
			item_q <= item_nxt;
		end
	end

	assign item_out = item_q;

endmodule

>>> tb/sv/ipv4_longest_prefix_router_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the ipv4 longest-prefix routing table
module ipv4_longest_prefix_router_test;

	localparam int TABLE_DEPTH = 64;
	localparam int NUM_PORTS   = 16;
	localparam int LATENCY     = TABLE_DEPTH + 1;
	localparam int CYCLE_LIMIT = 600000;
	localparam int FILL_ITEMS  = 1000;
	localparam int FULL_ITEMS  = 730;

	typedef struct {
		logic                       hold;
		lpr_pkg::lpr_req_t          kind;
		logic [lpr_pkg::ADDR_W-1:0] prefix;
		logic [lpr_pkg::LEN_W-1:0]  plen;
		logic                       hop_on;
		logic [lpr_pkg::ADDR_W-1:0] hop;
		logic [lpr_pkg::PORT_W-1:0] port;
		logic [lpr_pkg::ADDR_W-1:0] dest;
		logic [lpr_pkg::TTL_W-1:0]  ttl;
	} route_req_t;

	typedef struct {
		lpr_pkg::lpr_status_t       status;
		logic [lpr_pkg::PORT_W-1:0] port;
		logic [lpr_pkg::ADDR_W-1:0] send;
		logic [lpr_pkg::TTL_W-1:0]  ttl;
	} route_result_t;

	logic clk;
	logic arst_n;

	lpr_req_if req_bus();
	lpr_rsp_if rsp_bus();

	route_req_t    pending_q[$];
	route_result_t result_q[$];

	// routing table as predicted, lengths stored already limited to 32
	logic [lpr_pkg::ADDR_W-1:0] tbl_prefix [TABLE_DEPTH];
	int                         tbl_len    [TABLE_DEPTH];
	logic                       tbl_hop_on [TABLE_DEPTH];
	logic [lpr_pkg::ADDR_W-1:0] tbl_hop    [TABLE_DEPTH];
	logic [lpr_pkg::PORT_W-1:0] tbl_port   [TABLE_DEPTH];
	int                         tbl_count = 0;

	// routes the stimulus has issued, used to aim destinations at them
	logic [lpr_pkg::ADDR_W-1:0] gen_prefix[$];
	int                         gen_len[$];
	int                         gen_count = 0;

	int err_count = 0;
	int status_seen[5] = '{default: 0};
	int cycle = 0;
	int send_gap;
	bit send_burst;
	int recv_wait;
	bit recv_burst;

	ipv4_longest_prefix_router #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.NUM_PORTS  (NUM_PORTS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// applies one request to the predicted table and returns its result
	function automatic route_result_t resolve_route(input route_req_t r);
		route_result_t res;
		int best;
		int best_len;
		int l;
		bit hit;
		res.status = lpr_pkg::ST_ADDED;
		res.port = '0;
		res.send = '0;
		res.ttl = '0;
		best = 0;
		best_len = 0;
		hit = 1'b0;
		if (r.kind == lpr_pkg::REQ_ADD) begin
			if (tbl_count >= TABLE_DEPTH) begin
				res.status = lpr_pkg::ST_FULL;
			end else begin
				tbl_prefix[tbl_count] = r.prefix;
				tbl_len[tbl_count] = (r.plen > 32) ? 32 : int'(r.plen);
				tbl_hop_on[tbl_count] = r.hop_on;
				tbl_hop[tbl_count] = r.hop;
				tbl_port[tbl_count] = r.port;
				tbl_count++;
			end
			return res;
		end
		for (int i = 0; i < tbl_count; i++) begin
			l = tbl_len[i];
			if (l == 0 || ((tbl_prefix[i] ^ r.dest) >> (lpr_pkg::ADDR_W - l)) == 0) begin
				// strictly longer only, so the earliest route keeps a tie
				if (!hit || best_len < l) begin
					hit = 1'b1;
					best = i;
					best_len = l;
				end
			end
		end
		if (!hit) begin
			res.status = lpr_pkg::ST_NO_ROUTE;
		end else if (r.ttl <= 1) begin
			res.status = lpr_pkg::ST_TTL_DROP;
		end else begin
			res.status = lpr_pkg::ST_FORWARD;
			res.port = lpr_pkg::PORT_W'(tbl_port[best] % NUM_PORTS);
			res.send = tbl_hop_on[best] ? tbl_hop[best] : r.dest;
			res.ttl = r.ttl - lpr_pkg::TTL_W'(1);
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle, what, got, want);
		err_count++;
	endtask

	task automatic queue_route(input logic [31:0] prefix, input int plen, input bit hop_on,
			input logic [31:0] hop, input int port, input bit hold);
		route_req_t r;
		r.hold = hold;
		r.kind = lpr_pkg::REQ_ADD;
		r.prefix = prefix;
		r.plen = lpr_pkg::LEN_W'(plen);
		r.hop_on = hop_on;
		r.hop = hop;
		r.port = lpr_pkg::PORT_W'(port);
		r.dest = $urandom;
		r.ttl = lpr_pkg::TTL_W'($urandom_range(0, 255));
		pending_q.push_back(r);
		if (gen_count < TABLE_DEPTH) begin
			gen_prefix.push_back(prefix);
			gen_len.push_back(plen > 32 ? 32 : plen);
		end
		gen_count++;
	endtask

	task automatic queue_lookup(input logic [31:0] dest, input int ttl, input bit hold);
		route_req_t r;
		r.hold = hold;
		r.kind = lpr_pkg::REQ_LOOKUP;
		r.prefix = $urandom;
		r.plen = lpr_pkg::LEN_W'($urandom_range(0, 63));
		r.hop_on = 1'($urandom);
		r.hop = $urandom;
		r.port = lpr_pkg::PORT_W'($urandom_range(0, 15));
		r.dest = dest;
		r.ttl = lpr_pkg::TTL_W'(ttl);
		pending_q.push_back(r);
	endtask

	// destination inside an issued route, now and then one bit off inside the prefix
	function automatic logic [31:0] near_dest();
		int k;
		int l;
		logic [31:0] low;
		logic [31:0] d;
		if (gen_prefix.size() == 0)
			return $urandom;
		k = $urandom_range(0, gen_prefix.size() - 1);
		l = gen_len[k];
		low = 32'hFFFF_FFFF >> l;
		d = (gen_prefix[k] & ~low) | ($urandom & low);
		if (l > 0 && $urandom_range(0, 6) == 0)
			d ^= 32'h8000_0000 >> $urandom_range(0, l - 1);
		return d;
	endfunction

	function automatic int draw_ttl();
		int q;
		q = $urandom_range(0, 19);
		if (q < 3)
			return q;
		if (q == 3)
			return 255;
		return $urandom_range(0, 255);
	endfunction

	// random route: duplicate, nested below an issued one, or fresh
	task automatic add_random_route();
		int r;
		int k;
		int l;
		int q;
		logic [31:0] low;
		r = $urandom_range(0, 99);
		if (r < 45 && gen_prefix.size() != 0) begin
			k = $urandom_range(0, gen_prefix.size() - 1);
			l = gen_len[k];
			if (r >= 10)
				l = (l + $urandom_range(1, 8) > 32) ? 32 : l + $urandom_range(1, 8);
			low = 32'hFFFF_FFFF >> gen_len[k];
			if (l == 32 && $urandom_range(0, 3) == 0)
				l = $urandom_range(33, 63);
			queue_route((gen_prefix[k] & ~low) | ($urandom & low), l, 1'($urandom),
				$urandom, $urandom_range(0, 15), $urandom_range(0, 299) == 0);
		end else begin
			q = $urandom_range(0, 9);
			if (q < 4)
				l = $urandom_range(1, 8);
			else if (q < 7)
				l = $urandom_range(9, 24);
			else if (q < 9)
				l = $urandom_range(25, 32);
			else
				l = $urandom_range(33, 63);
			queue_route($urandom, l, 1'($urandom), $urandom, $urandom_range(0, 15),
				$urandom_range(0, 299) == 0);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : driver
		route_req_t nxt;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.req_type <= '0;
			req_bus.net_prefix <= '0;
			req_bus.prefix_len <= '0;
			req_bus.hop_present <= 1'b0;
			req_bus.hop_addr <= '0;
			req_bus.port_index <= '0;
			req_bus.dest_addr <= '0;
			req_bus.ttl_in <= '0;
			send_gap <= 0;
			send_burst <= 1'b0;
		end else if (req_bus.valid && !req_bus.ready) begin
			// transfer not taken yet, hold the item
		end else if (send_gap != 0) begin
			send_gap <= send_gap - 1;
			req_bus.valid <= 1'b0;
		end else if (pending_q.size() != 0 &&
				(!pending_q[0].hold || (result_q.size() == 0 && !req_bus.valid))) begin
			nxt = pending_q.pop_front();
			req_bus.req_type <= nxt.kind;
			req_bus.net_prefix <= nxt.prefix;
			req_bus.prefix_len <= nxt.plen;
			req_bus.hop_present <= nxt.hop_on;
			req_bus.hop_addr <= nxt.hop;
			req_bus.port_index <= nxt.port;
			req_bus.dest_addr <= nxt.dest;
			req_bus.ttl_in <= nxt.ttl;
			req_bus.valid <= 1'b1;
			if ($urandom_range(0, 49) == 0)
				send_burst <= !send_burst;
			send_gap <= send_burst ? 0 : $urandom_range(0, 19);
		end else begin
			req_bus.valid <= 1'b0;
		end
	end

	// result receiver with random stalls
	always @(posedge clk or negedge arst_n) begin : receiver
		int w;
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			recv_wait <= 0;
			recv_burst <= 1'b0;
		end else if (rsp_bus.valid && rsp_bus.ready) begin
			if ($urandom_range(0, 39) == 0)
				recv_burst <= !recv_burst;
			w = recv_burst ? 0 : $urandom_range(0, 19);
			recv_wait <= w;
			rsp_bus.ready <= (w == 0);
		end else if (recv_wait != 0) begin
			recv_wait <= recv_wait - 1;
			rsp_bus.ready <= (recv_wait == 1);
		end else begin
			rsp_bus.ready <= 1'b1;
		end
	end

	// predicts on every request transfer, checks every result transfer
	always @(posedge clk) begin : monitor
		route_req_t seen;
		route_result_t want;
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				seen.hold = 1'b0;
				seen.kind = lpr_pkg::lpr_req_t'(req_bus.req_type);
				seen.prefix = req_bus.net_prefix;
				seen.plen = req_bus.prefix_len;
				seen.hop_on = req_bus.hop_present;
				seen.hop = req_bus.hop_addr;
				seen.port = req_bus.port_index;
				seen.dest = req_bus.dest_addr;
				seen.ttl = req_bus.ttl_in;
				result_q.push_back(resolve_route(seen));
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (result_q.size() == 0) begin
					report_mismatch("result with none pending, status",
						32'(rsp_bus.status), '0);
				end else begin
					want = result_q.pop_front();
					status_seen[want.status]++;
					if (rsp_bus.status !== want.status)
						report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
					if (rsp_bus.out_port !== want.port)
						report_mismatch("out_port", 32'(rsp_bus.out_port), 32'(want.port));
					if (rsp_bus.send_addr !== want.send)
						report_mismatch("send_addr", rsp_bus.send_addr, want.send);
					if (rsp_bus.ttl_out !== want.ttl)
						report_mismatch("ttl_out", 32'(rsp_bus.ttl_out), 32'(want.ttl));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle == CYCLE_LIMIT) begin
			$display("timeout, %0d results still pending", result_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.req_type = '0;
		req_bus.net_prefix = '0;
		req_bus.prefix_len = '0;
		req_bus.hop_present = 1'b0;
		req_bus.hop_addr = '0;
		req_bus.port_index = '0;
		req_bus.dest_addr = '0;
		req_bus.ttl_in = '0;
		rsp_bus.ready = 1'b0;

		// empty table, no route even with a low ttl
		queue_lookup(32'hFFFF_FFFF, 0, 1'b0);
		queue_lookup(32'h0000_0000, 255, 1'b0);
		queue_route(32'h0A00_0000, 8, 1'b0, 32'hFFFF_FFFF, 3, 1'b0);
		queue_route(32'h0A01_0000, 16, 1'b1, 32'hC0A8_0001, 15, 1'b0);
		queue_route(32'h0A01_0203, 32, 1'b0, 32'h0000_0000, 0, 1'b0);
		// same length as the earlier /16, must lose the tie
		queue_route(32'h0A01_FFFF, 16, 1'b1, 32'h0102_0304, 7, 1'b0);
		// lengths above 32 match and rank as 32
		queue_route(32'hFFFF_FFFF, 63, 1'b1, 32'hFFFF_FFFF, 9, 1'b0);
		queue_route(32'hAAAA_AAAB, 31, 1'b1, 32'h5555_5555, 12, 1'b0);
		queue_route(32'hAAAA_AAAA, 33, 1'b0, 32'h0000_0000, 5, 1'b0);
		queue_route(32'hAAAA_AAAB, 40, 1'b1, 32'h1234_5678, 2, 1'b0);
		queue_lookup(32'h0A01_0203, 2, 1'b0);
		queue_lookup(32'h0A01_0909, 255, 1'b1);
		queue_lookup(32'h0AC8_0001, 64, 1'b0);
		queue_lookup(32'h0A01_0203, 1, 1'b0);
		queue_lookup(32'h0A01_0203, 0, 1'b0);
		queue_lookup(32'h0B00_0000, 64, 1'b0);
		queue_lookup(32'hFFFF_FFFF, 200, 1'b0);
		queue_lookup(32'hFFFF_FFFE, 200, 1'b0);
		queue_lookup(32'hAAAA_AAAA, 3, 1'b0);
		queue_lookup(32'hAAAA_AAAB, 3, 1'b0);

		// fill the table but keep the last slot for the default route
		repeat (FILL_ITEMS) begin
			if (gen_count < TABLE_DEPTH - 1 && $urandom_range(0, 99) < 30)
				add_random_route();
			else
				queue_lookup(($urandom_range(0, 3) == 0) ? $urandom : near_dest(),
					draw_ttl(), $urandom_range(0, 299) == 0);
		end

		// default route takes the last slot, the table is full from here on
		queue_route(32'h0000_0000, 0, 1'b1, 32'h0101_0101, 1, 1'b1);
		queue_lookup(32'h0B00_0000, 9, 1'b0);
		queue_lookup(32'h0B00_0000, 1, 1'b0);
		queue_route(32'hC0A8_0000, 16, 1'b1, 32'hC0A8_0001, 4, 1'b0);

		repeat (FULL_ITEMS) begin
			if ($urandom_range(0, 99) < 8)
				queue_route($urandom, $urandom_range(0, 63), 1'($urandom), $urandom,
					$urandom_range(0, 15), 1'b0);
			else
				queue_lookup(($urandom_range(0, 4) == 0) ? $urandom : near_dest(),
					draw_ttl(), $urandom_range(0, 299) == 0);
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_q.size() != 0 || req_bus.valid || result_q.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		$display("routes stored %0d, adds refused on a full table %0d",
			status_seen[lpr_pkg::ST_ADDED], status_seen[lpr_pkg::ST_FULL]);
		$display("datagrams forwarded %0d, dropped without route %0d, dropped on ttl %0d",
			status_seen[lpr_pkg::ST_FORWARD], status_seen[lpr_pkg::ST_NO_ROUTE],
			status_seen[lpr_pkg::ST_TTL_DROP]);
		if (err_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/lpr_pkg.sv
hdl/lpr_ifs.sv
hdl/lpr_cell.sv
hdl/ipv4_longest_prefix_router.sv
tb/sv/ipv4_longest_prefix_router_test.sv
